@@ src/fcbs_pkg.sv @@
// shared types, widths and register codes for the frustum cull block
`timescale 1ns / 1ps
package fcbs_pkg;

    // sizes
    localparam int MAX_PLANES = 6;
    localparam int PLANE_REGS = 6;
    localparam int NUM_LANES  = (MAX_PLANES < PLANE_REGS) ? MAX_PLANES : PLANE_REGS;
    localparam int COORD_BITS = 16;
    localparam int NORM_BITS  = 16;
    localparam int FRAC_BITS  = 14;
    localparam int PLANE_BITS = 64;
    localparam int CNT_BITS   = 3;
    localparam int INDEX_BITS = 3;
    localparam int CFG_BITS   = PLANE_BITS;

    // arithmetic widths
    localparam int PROD_BITS = COORD_BITS + NORM_BITS;
    localparam int SUM_BITS  = COORD_BITS + NORM_BITS + 3;

    // stream widths
    localparam int IN_BITS   = 1 + 7 * COORD_BITS;
    localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA = 8;

    // configuration register indexes
    localparam logic [INDEX_BITS-1:0] REG_PLANE_A       = 3'd0;
    localparam logic [INDEX_BITS-1:0] REG_PLANE_B       = 3'd1;
    localparam logic [INDEX_BITS-1:0] REG_PLANE_C       = 3'd2;
    localparam logic [INDEX_BITS-1:0] REG_PLANE_D       = 3'd3;
    localparam logic [INDEX_BITS-1:0] REG_PLANE_E       = 3'd4;
    localparam logic [INDEX_BITS-1:0] REG_PLANE_F       = 3'd5;
    localparam logic [INDEX_BITS-1:0] REG_PLANES_IN_USE = 3'd6;

    localparam logic [CNT_BITS-1:0] PLANES_RESET = 3'd6;

    // test kinds
    localparam logic OP_BOX    = 1'b0;
    localparam logic OP_SPHERE = 1'b1;

    // one object under test
    typedef struct packed {
        logic                         op;
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic signed [COORD_BITS-1:0] center_z;
        logic signed [COORD_BITS-1:0] half_x;
        logic signed [COORD_BITS-1:0] half_y;
        logic signed [COORD_BITS-1:0] half_z;
        logic signed [COORD_BITS-1:0] margin;
    } obj_t;

endpackage

@@ src/frustum_cull_box_sphere.sv @@
// top level: box or sphere test against up to six configured planes
// throughput: one item per cycle while m_tready is high, all plane lanes work in parallel
// stages: input register, then products, sums and compares into the result register
// a held result stalls the input only while both registers are full
// reset: synchronous active low; planes clear to zero, six planes in use, pipeline empty
`timescale 1ns / 1ps
module frustum_cull_box_sphere (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [fcbs_pkg::INDEX_BITS-1:0]  cfg_index,
    input  logic [fcbs_pkg::CFG_BITS-1:0]    cfg_wdata,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // op, center_x, center_y, center_z, half_x, half_y, half_z, margin, zero pad
    input  logic [fcbs_pkg::IN_TDATA-1:0]    s_tdata,
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // inside_res, zero pad
    output logic [fcbs_pkg::OUT_TDATA-1:0]   m_tdata
);
    import fcbs_pkg::*;

    localparam int C = COORD_BITS;

    logic [PLANE_BITS-1:0] plane_reg [PLANE_REGS];
    logic [CNT_BITS-1:0]   planes_in_use_reg;

    obj_t obj_next, obj_reg;
    logic v1_reg, v2_reg;
    logic adv1, adv2;
    logic inside_reg;
    logic [NUM_LANES-1:0] reject;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PLANE_REGS; i++) begin
                plane_reg[i] <= '0;
            end
            planes_in_use_reg <= PLANES_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index) inside
                REG_PLANE_A, REG_PLANE_B, REG_PLANE_C,
                REG_PLANE_D, REG_PLANE_E, REG_PLANE_F: begin
                    plane_reg[cfg_index] <= cfg_wdata;
                end
                REG_PLANES_IN_USE: begin
                    planes_in_use_reg <= cfg_wdata[CNT_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline advance, each stage moves when the next one is free or moving
    assign adv2     = !v2_reg || m_tready;
    assign adv1     = !v1_reg || adv2;
    assign s_tready = adv1;

    // unpack the input item
    assign obj_next.op       = s_tdata[0];
    assign obj_next.center_x = s_tdata[1+C-1:1];
    assign obj_next.center_y = s_tdata[1+2*C-1:1+C];
    assign obj_next.center_z = s_tdata[1+3*C-1:1+2*C];
    assign obj_next.half_x   = s_tdata[1+4*C-1:1+3*C];
    assign obj_next.half_y   = s_tdata[1+5*C-1:1+4*C];
    assign obj_next.half_z   = s_tdata[1+6*C-1:1+5*C];
    assign obj_next.margin   = s_tdata[1+7*C-1:1+6*C];

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_tvalid;
            if (adv2) v2_reg <= v1_reg;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (adv1 && s_tvalid) begin
            obj_reg <= obj_next;
        end
    end

    // one lane per plane that can be tested
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        fcbs_plane_lane u_lane (
            .obj    (obj_reg),
            .plane  (plane_reg[g]),
            .active (planes_in_use_reg > CNT_BITS'(g)),
            .reject (reject[g])
        );
    end

    // result register
    always_ff @(posedge aclk) begin
        if (adv2 && v1_reg) begin
            inside_reg <= ~|reject;
        end
    end

    assign m_tvalid = v2_reg;
    assign m_tdata  = {{(OUT_TDATA-1){1'b0}}, inside_reg};

endmodule

@@ src/fcbs_plane_lane.sv @@
// one plane test: products, signed distance plus radius, sign check
`timescale 1ns / 1ps
module fcbs_plane_lane (
    input  fcbs_pkg::obj_t                  obj,
    input  logic [fcbs_pkg::PLANE_BITS-1:0] plane,
    input  logic                            active,
    output logic                            reject
);
    import fcbs_pkg::*;

    logic signed [NORM_BITS-1:0]  nx, ny, nz, offs;
    logic        [NORM_BITS-1:0]  anx, any_n, anz;
    logic        [COORD_BITS-1:0] ahx, ahy, ahz;

    logic signed [PROD_BITS-1:0]  px, py, pz;
    logic        [PROD_BITS-1:0]  rx, ry, rz;

    logic signed [SUM_BITS-1:0]   plane_dist, rad_box, rad_sph, rad, total;

    // unpack the plane and take magnitudes
    assign nx   = plane[NORM_BITS-1:0];
    assign ny   = plane[2*NORM_BITS-1:NORM_BITS];
    assign nz   = plane[3*NORM_BITS-1:2*NORM_BITS];
    assign offs = plane[4*NORM_BITS-1:3*NORM_BITS];

    assign anx   = nx[NORM_BITS-1] ? NORM_BITS'(-nx) : nx;
    assign any_n = ny[NORM_BITS-1] ? NORM_BITS'(-ny) : ny;
    assign anz   = nz[NORM_BITS-1] ? NORM_BITS'(-nz) : nz;
    assign ahx   = obj.half_x[COORD_BITS-1] ? COORD_BITS'(-obj.half_x) : obj.half_x;
    assign ahy   = obj.half_y[COORD_BITS-1] ? COORD_BITS'(-obj.half_y) : obj.half_y;
    assign ahz   = obj.half_z[COORD_BITS-1] ? COORD_BITS'(-obj.half_z) : obj.half_z;

    // products for the dot term and the box radius
    assign px = nx * obj.center_x;
    assign py = ny * obj.center_y;
    assign pz = nz * obj.center_z;
    assign rx = PROD_BITS'(anx) * PROD_BITS'(ahx);
    assign ry = PROD_BITS'(any_n) * PROD_BITS'(ahy);
    assign rz = PROD_BITS'(anz) * PROD_BITS'(ahz);

    // signed distance, effective radius, reject when distance + radius < 0
    assign plane_dist = SUM_BITS'(px) + SUM_BITS'(py) + SUM_BITS'(pz)
                      - (SUM_BITS'(offs) <<< FRAC_BITS);
    assign rad_box = signed'(SUM_BITS'(rx) + SUM_BITS'(ry) + SUM_BITS'(rz));
    assign rad_sph = SUM_BITS'(obj.margin) <<< FRAC_BITS;
    assign rad     = (obj.op == OP_SPHERE) ? rad_sph : rad_box;
    assign total   = plane_dist + rad;
    assign reject  = active & total[SUM_BITS-1];

endmodule

@@ bench/frustum_cull_box_sphere_test.sv @@
// testbench for the frustum cull block: random and directed box and sphere items, self checked
`timescale 1ns / 1ps
module frustum_cull_box_sphere_test;
    import fcbs_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [INDEX_BITS-1:0] REG_UNUSED = 3'd7;
    localparam logic [INDEX_BITS-1:0] PLANE_INDEX [PLANE_REGS] = '{
        REG_PLANE_A, REG_PLANE_B, REG_PLANE_C, REG_PLANE_D, REG_PLANE_E, REG_PLANE_F
    };

    // holds a copy of the plane registers, predicts inside_res, matches results in order
    class cull_scoreboard;
        logic [PLANE_BITS-1:0] planes [PLANE_REGS];
        logic [CNT_BITS-1:0]   active_planes;
        bit                    inside_queue [$];
        int                    errors;

        function new();
            foreach (planes[i]) planes[i] = '0;
            active_planes = PLANES_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
            if (idx <= REG_PLANE_F) begin
                planes[idx] = value;
            end else if (idx == REG_PLANES_IN_USE) begin
                active_planes = value[CNT_BITS-1:0];
            end
        endfunction

        function longint magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // exact Q.14 comparison of signed distance against the effective radius
        function bit predict_inside(obj_t o);
            longint cx, cy, cz, hx, hy, hz, mg;
            longint nx, ny, nz, d, plane_dist, rad;
            int count;
            cx = $signed(o.center_x);
            cy = $signed(o.center_y);
            cz = $signed(o.center_z);
            hx = magnitude($signed(o.half_x));
            hy = magnitude($signed(o.half_y));
            hz = magnitude($signed(o.half_z));
            mg = $signed(o.margin);
            count = active_planes;
            if (count > NUM_LANES) count = NUM_LANES;
            for (int i = 0; i < count; i++) begin
                nx = $signed(planes[i][15:0]);
                ny = $signed(planes[i][31:16]);
                nz = $signed(planes[i][47:32]);
                d  = $signed(planes[i][63:48]);
                plane_dist = nx * cx + ny * cy + nz * cz - d * (longint'(1) << FRAC_BITS);
                if (o.op == OP_BOX)
                    rad = hx * magnitude(nx) + hy * magnitude(ny) + hz * magnitude(nz);
                else
                    rad = mg * (longint'(1) << FRAC_BITS);
                if (plane_dist < -rad) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_object(obj_t o);
            inside_queue = {inside_queue, predict_inside(o)};
        endfunction

        function void check_result(logic [OUT_TDATA-1:0] data);
            bit want;
            if (inside_queue.size() == 0) begin
                $display("%0t: result inside_res %0d with nothing expected", $time, data[0]);
                errors++;
            end else begin
                want = inside_queue.pop_front();
                if (data[0] !== want) begin
                    $display("%0t: inside_res expected %0d, got %0d", $time, want, data[0]);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return inside_queue.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]   cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_TDATA-1:0]  m_tdata;

    cull_scoreboard board;
    int  cycle_count = 0;
    bit  rx_stalls = 1'b0;
    int  hold_asks = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    int  stall_left = 0;

    frustum_cull_box_sphere dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // result side: check each accepted item, then choose m_tready for the next edge
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) board.check_result(m_tdata);
        if (hold_asks != hold_served) begin
            hold_served = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (rx_stalls && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    function automatic logic [IN_TDATA-1:0] pack_object(obj_t o);
        logic [IN_TDATA-1:0] v;
        v = '0;
        v[0] = o.op;
        v[1 + 0 * COORD_BITS +: COORD_BITS] = o.center_x;
        v[1 + 1 * COORD_BITS +: COORD_BITS] = o.center_y;
        v[1 + 2 * COORD_BITS +: COORD_BITS] = o.center_z;
        v[1 + 3 * COORD_BITS +: COORD_BITS] = o.half_x;
        v[1 + 4 * COORD_BITS +: COORD_BITS] = o.half_y;
        v[1 + 5 * COORD_BITS +: COORD_BITS] = o.half_z;
        v[1 + 6 * COORD_BITS +: COORD_BITS] = o.margin;
        return v;
    endfunction

    function automatic obj_t make_obj(logic op, int cx, int cy, int cz,
                                      int hx, int hy, int hz, int mg);
        obj_t o;
        o.op = op;
        o.center_x = 16'(cx);
        o.center_y = 16'(cy);
        o.center_z = 16'(cz);
        o.half_x = 16'(hx);
        o.half_y = 16'(hy);
        o.half_z = 16'(hz);
        o.margin = 16'(mg);
        return o;
    endfunction

    function automatic int spread(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // any bit pattern in every field
    function automatic obj_t any_object();
        return make_obj($urandom_range(0, 1), $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
    endfunction

    // objects around the volume, so both outcomes show up
    function automatic obj_t object_near(int span);
        return make_obj($urandom_range(0, 1), spread(span), spread(span), spread(span),
                        spread(span / 4), spread(span / 4), spread(span / 4),
                        spread(span / 4));
    endfunction

    function automatic logic [PLANE_BITS-1:0] plane_word(int nx, int ny, int nz, int d);
        return {16'(d), 16'(nz), 16'(ny), 16'(nx)};
    endfunction

    function automatic logic [PLANE_BITS-1:0] random_plane(int span);
        return plane_word(spread(1 << FRAC_BITS), spread(1 << FRAC_BITS),
                          spread(1 << FRAC_BITS), -int'($urandom_range(span / 2, 2 * span)));
    endfunction

    task automatic write_reg(logic [INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        board.write_reg(idx, value);
        @(posedge aclk);
    endtask

    // offer one item after an optional gap and wait for the handshake
    task automatic send_object(obj_t o, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_object(o);
        do @(posedge aclk); while (!s_tready);
        board.note_object(o);
    endtask

    task automatic run_batch(int count, int span, int full_pct, bit tx_gaps);
        obj_t o;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < full_pct) o = any_object();
            else o = object_near(span);
            send_object(o, tx_gaps ? pick_gap() : 0);
        end
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // axis aligned box volume of half size lim
    task automatic load_axis_box(int lim);
        write_reg(REG_PLANE_A, plane_word(1 << FRAC_BITS, 0, 0, -lim));
        write_reg(REG_PLANE_B, plane_word(-(1 << FRAC_BITS), 0, 0, -lim));
        write_reg(REG_PLANE_C, plane_word(0, 1 << FRAC_BITS, 0, -lim));
        write_reg(REG_PLANE_D, plane_word(0, -(1 << FRAC_BITS), 0, -lim));
        write_reg(REG_PLANE_E, plane_word(0, 0, 1 << FRAC_BITS, -lim));
        write_reg(REG_PLANE_F, plane_word(0, 0, -(1 << FRAC_BITS), -lim));
    endtask

    task automatic load_random_planes(int span);
        for (int i = 0; i < PLANE_REGS; i++) write_reg(PLANE_INDEX[i], random_plane(span));
    endtask

    initial begin
        board = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset state: zero planes, six in use; only a sphere with a negative margin rejects
        rx_stalls = 1'b1;
        send_object(make_obj(OP_BOX, 32767, -32768, 0, -32768, 32767, -32768, 0), 0);
        send_object(make_obj(OP_BOX, 0, 0, 0, 0, 0, 0, -32768), 1);
        send_object(make_obj(OP_SPHERE, 0, 0, 0, 0, 0, 0, -32768), 0);
        send_object(make_obj(OP_SPHERE, -32768, 32767, -32768, 0, 0, 0, 32767), 0);
        send_object(make_obj(OP_SPHERE, 5, 5, 5, 0, 0, 0, 0), 2);
        send_object(make_obj(OP_SPHERE, 5, 5, 5, 0, 0, 0, -1), 0);
        drain();

        // axis box of half size 1000, writes to the unused index must be dropped
        load_axis_box(1000);
        write_reg(REG_PLANES_IN_USE, 6);
        write_reg(REG_UNUSED, '1);
        // touching the x = -1000 face exactly counts as inside
        send_object(make_obj(OP_BOX, -1005, 0, 0, 5, 0, 0, 0), 0);
        send_object(make_obj(OP_BOX, -1006, 0, 0, -5, 0, 0, 0), 0);
        send_object(make_obj(OP_SPHERE, -1007, 0, 0, 0, 0, 0, 7), 0);
        send_object(make_obj(OP_SPHERE, -1008, 0, 0, 0, 0, 0, 7), 0);
        // negative margin shrinks the volume
        send_object(make_obj(OP_SPHERE, -997, 0, 0, 9, 9, 9, -3), 0);
        send_object(make_obj(OP_SPHERE, -998, 0, 0, 9, 9, 9, -3), 0);
        // field extremes
        send_object(make_obj(OP_BOX, 32767, 0, 0, 0, 0, 0, 32767), 0);
        send_object(make_obj(OP_BOX, 32767, -32768, 32767, -32768, -32768, -32768, 0), 3);
        send_object(make_obj(OP_BOX, -32768, 0, 0, 32767, 0, 0, 0), 0);
        send_object(make_obj(OP_SPHERE, -32768, -32768, -32768, 0, 0, 0, 32767), 0);
        send_object(make_obj(OP_SPHERE, 0, 0, 0, 32767, 32767, 32767, -32768), 0);
        send_object(make_obj(OP_SPHERE, 32767, 32767, 32767, -1, -1, -1, -1), 0);
        run_batch(300, 1500, 10, 1'b1);
        drain();

        // random planes, plane F left out, no idling on either side
        rx_stalls = 1'b0;
        load_random_planes(1000);
        write_reg(REG_PLANES_IN_USE, 5);
        run_batch(300, 1500, 5, 1'b0);
        drain();

        // no planes in use
        write_reg(REG_PLANES_IN_USE, 0);
        run_batch(100, 1500, 50, 1'b1);
        drain();

        // count above the plane limit is clamped
        rx_stalls = 1'b1;
        load_random_planes(600);
        write_reg(REG_PLANES_IN_USE, 7);
        run_batch(250, 1000, 10, 1'b0);
        drain();

        // extreme plane words
        write_reg(REG_PLANE_A, '1);
        write_reg(REG_PLANE_B, 64'h8000_8000_8000_8000);
        write_reg(REG_PLANE_C, 64'h7fff_7fff_7fff_7fff);
        write_reg(REG_PLANE_D, 64'h8000_7fff_8000_7fff);
        write_reg(REG_PLANE_E, 64'h7fff_8000_7fff_8000);
        write_reg(REG_PLANE_F, '0);
        write_reg(REG_PLANES_IN_USE, 6);
        run_batch(250, 4000, 40, 1'b1);
        drain();

        // few planes; the result side holds off so the pipeline fills
        load_axis_box(800);
        write_reg(REG_PLANES_IN_USE, $urandom_range(1, 4));
        run_batch(150, 1200, 10, 1'b1);
        hold_asks++;
        run_batch(60, 1200, 10, 1'b0);
        run_batch(150, 1200, 10, 1'b1);
        drain();

        // last random setting
        load_random_planes(2000);
        write_reg(REG_PLANES_IN_USE, $urandom_range(1, 6));
        run_batch(300, 2500, 15, 1'b1);
        drain();

        if (board.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

@@ files.f @@
src/fcbs_pkg.sv
src/fcbs_plane_lane.sv
src/frustum_cull_box_sphere.sv
bench/frustum_cull_box_sphere_test.sv
